// ===== rtl/vsbm_pkg.sv =====
// ============================================================================
// vsbm_pkg
// Shared types, constants, filter coefficients and saturation helpers for
// the VSB modulator / demodulator filter chain.
// ============================================================================
`default_nettype none

package vsbm_pkg;

  // Sample and arithmetic widths
  localparam int DATA_W     = 16;
  localparam int MUL_W      = DATA_W + 1;          // signed operand, room for unsigned gain
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = 40;                  // 128 products of 31 bits plus sign
  localparam int COEF_IDX_W = 7;                   // coefficient slots: 128
  localparam int PTR_W      = COEF_IDX_W + 1;      // room for head + depth

  // Default configuration
  localparam int BANDPASS_TAPS_DEF = 49;
  localparam int LOWPASS_TAPS_DEF  = 97;
  localparam logic [DATA_W-1:0] GAIN_RESET = 16'd22938;   // 2.8 in Q13

  // Configuration register map (word index taken from paddr[2])
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_OUTPUT_GAIN = 1'b0;

  // Fractional shifts
  localparam int Q15_SHIFT = 15;
  localparam int Q13_SHIFT = 13;

  localparam int BP_COEF_LEN = 49;
  localparam int LP_COEF_LEN = 97;
  localparam int BP_IDX_W    = $clog2(BP_COEF_LEN);
  localparam int LP_IDX_W    = $clog2(LP_COEF_LEN);

  localparam logic signed [DATA_W-1:0] BP_COEF [BP_COEF_LEN] = '{
       16'sd56,    -16'sd46,   -16'sd39,   -16'sd39,   -16'sd82,    16'sd85,
      16'sd311,      16'sd7,  -16'sd590,  -16'sd308,   16'sd793,   16'sd816,
     -16'sd773,  -16'sd1442,   16'sd419,  16'sd2005,   16'sd282, -16'sd2297,
    -16'sd1219,   16'sd2156,  16'sd2169, -16'sd1540, -16'sd2880,   16'sd560,
     16'sd3142,    16'sd560, -16'sd2880, -16'sd1540,  16'sd2169,  16'sd2156,
    -16'sd1219,  -16'sd2297,   16'sd282,  16'sd2005,   16'sd419, -16'sd1442,
     -16'sd773,    16'sd816,   16'sd793,  -16'sd308,  -16'sd590,     16'sd7,
      16'sd311,     16'sd85,   -16'sd82,   -16'sd39,   -16'sd39,   -16'sd46,
       16'sd56
  };

  localparam logic signed [DATA_W-1:0] LP_COEF [LP_COEF_LEN] = '{
        16'sd0,      16'sd3,      16'sd7,     16'sd10,     16'sd16,     16'sd20,
       16'sd26,     16'sd33,     16'sd36,     16'sd43,     16'sd46,     16'sd46,
       16'sd43,     16'sd39,     16'sd29,     16'sd16,      16'sd0,    -16'sd23,
      -16'sd49,    -16'sd79,   -16'sd111,   -16'sd144,   -16'sd177,   -16'sd210,
     -16'sd233,   -16'sd252,   -16'sd262,   -16'sd259,   -16'sd242,   -16'sd210,
     -16'sd157,    -16'sd88,      16'sd0,    16'sd108,    16'sd233,    16'sd377,
      16'sd531,    16'sd698,    16'sd872,   16'sd1045,   16'sd1222,   16'sd1389,
     16'sd1547,   16'sd1688,   16'sd1812,   16'sd1910,   16'sd1986,   16'sd2028,
     16'sd2045,   16'sd2028,   16'sd1986,   16'sd1910,   16'sd1812,   16'sd1688,
     16'sd1547,   16'sd1389,   16'sd1222,   16'sd1045,    16'sd872,    16'sd698,
      16'sd531,    16'sd377,    16'sd233,    16'sd108,      16'sd0,    -16'sd88,
     -16'sd157,   -16'sd210,   -16'sd242,   -16'sd259,   -16'sd262,   -16'sd252,
     -16'sd233,   -16'sd210,   -16'sd177,   -16'sd144,   -16'sd111,    -16'sd79,
      -16'sd49,    -16'sd23,      16'sd0,     16'sd16,     16'sd29,     16'sd39,
       16'sd43,     16'sd46,     16'sd46,     16'sd43,     16'sd36,     16'sd33,
       16'sd26,     16'sd20,     16'sd16,     16'sd10,      16'sd7,      16'sd3,
        16'sd0
  };

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32768);

  // Slots past the end of a coefficient list read as zero.
  function automatic logic signed [DATA_W-1:0] bp_coef_f(input logic [COEF_IDX_W-1:0] idx);
    logic signed [DATA_W-1:0] c;
    c = '0;
    if (idx < COEF_IDX_W'(BP_COEF_LEN)) c = BP_COEF[idx[BP_IDX_W-1:0]];
    return c;
  endfunction

  function automatic logic signed [DATA_W-1:0] lp_coef_f(input logic [COEF_IDX_W-1:0] idx);
    logic signed [DATA_W-1:0] c;
    c = '0;
    if (idx < COEF_IDX_W'(LP_COEF_LEN)) c = LP_COEF[idx[LP_IDX_W-1:0]];
    return c;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat16_f(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) begin
      r = 16'sh7fff;
    end else if (v < SAT_MIN) begin
      r = -16'sh8000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vsbm_ram.sv =====
// ============================================================================
// vsbm_ram
// Generic single-clock RAM with one write port and one registered read port.
// ============================================================================
`default_nettype none

module vsbm_ram
  import vsbm_pkg::*;
#(
  parameter int WIDTH = DATA_W,
  parameter int DEPTH = BANDPASS_TAPS_DEF - 1,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/vsb_modem_fir_chain.sv =====
// Flow: an input beat is taken only in the idle state, so a new item is not accepted until the
//   previous result has been handed to the output register; the single multiply-accumulate unit
//   walks both delay-line memories one tap a cycle.
// Reset: synchronous, active low. Afterwards both delay lines are cleared to zero
//   with in_tready low; gain returns to 2.8.
// ============================================================================
// vsb_modem_fir_chain
// Q15 DSB mixer, band-pass VSB shaping FIR, coherent remixer, low-pass FIR
// and Q13 output gain, all sharing one multiplier and two history memories.
// ============================================================================
`default_nettype none

module vsb_modem_fir_chain
  import vsbm_pkg::*;
#(
  parameter int BANDPASS_TAPS = BANDPASS_TAPS_DEF,
  parameter int LOWPASS_TAPS  = LOWPASS_TAPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,    // [15:0] message_sample, [31:16] carrier_sample
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,   // [15:0] vsb_sample, [31:16] demod_sample
  // Configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int BP_DEPTH = BANDPASS_TAPS - 1;
  localparam int LP_DEPTH = LOWPASS_TAPS - 1;
  localparam int BP_AW    = (BP_DEPTH > 1) ? $clog2(BP_DEPTH) : 1;
  localparam int LP_AW    = (LP_DEPTH > 1) ? $clog2(LP_DEPTH) : 1;
  localparam int CLR_LEN  = (BP_DEPTH > LP_DEPTH) ? BP_DEPTH : LP_DEPTH;

  localparam logic [COEF_IDX_W-1:0] BP_LAST  = COEF_IDX_W'(BANDPASS_TAPS - 1);
  localparam logic [COEF_IDX_W-1:0] LP_LAST  = COEF_IDX_W'(LOWPASS_TAPS - 1);
  localparam logic [COEF_IDX_W-1:0] CLR_LAST = COEF_IDX_W'(CLR_LEN - 1);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_MIX   = 9'b000000100,
    S_LOAD  = 9'b000001000,
    S_MAC   = 9'b000010000,
    S_DRAIN = 9'b000100000,
    S_SUM   = 9'b001000000,
    S_GAIN  = 9'b010000000,
    S_SCALE = 9'b100000000
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    lp_stage_r;
  logic [COEF_IDX_W-1:0]   tap_cnt_r;
  logic [COEF_IDX_W-1:0]   clr_cnt_r;
  logic [BP_AW-1:0]        bp_head_r;
  logic [LP_AW-1:0]        lp_head_r;
  logic                    mac_vld_r;
  logic                    out_tvalid_r;
  logic [31:0]             out_tdata_r;
  logic [DATA_W-1:0]       gain_r;

  logic signed [DATA_W-1:0] msg_r, car_r, x_r, vsb_r, lp_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [DATA_W-1:0] coef;
  logic signed [DATA_W-1:0] hist_rd;
  logic signed [DATA_W-1:0] mix_val, fir_val, scale_val;
  logic                     prod_en;
  logic                     in_beat, out_free, cfg_wr;
  logic [COEF_IDX_W-1:0]    tap_last;

  logic [PTR_W-1:0]         head_w, depth_w, cnt_w, rd_w;
  logic [BP_AW-1:0]         bp_next;
  logic [LP_AW-1:0]         lp_next;
  logic                     clearing;
  logic                     bp_we, lp_we;
  logic [BP_AW-1:0]         bp_waddr;
  logic [LP_AW-1:0]         lp_waddr;
  logic [DATA_W-1:0]        bp_wdata, lp_wdata, bp_rdata, lp_rdata;

  assign in_tready  = (state_r == S_IDLE);
  assign in_beat    = in_tvalid & in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign tap_last   = lp_stage_r ? LP_LAST : BP_LAST;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready &
                      (cfg_paddr[2] == REG_OUTPUT_GAIN);
  assign cfg_prdata = (cfg_paddr[2] == REG_OUTPUT_GAIN) ? {16'b0, gain_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_wr) begin
      gain_r <= cfg_pwdata[DATA_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // History memories: circular buffers, the head holds the newest sample
  // --------------------------------------------------------------------------
  assign clearing = (state_r == S_CLEAR);
  assign bp_next  = (bp_head_r == BP_AW'(BP_DEPTH - 1)) ? '0 : bp_head_r + 1'b1;
  assign lp_next  = (lp_head_r == LP_AW'(LP_DEPTH - 1)) ? '0 : lp_head_r + 1'b1;

  // Tap k (k >= 1) of the history sits k - 1 entries behind the head.
  assign head_w  = lp_stage_r ? PTR_W'(lp_head_r) : PTR_W'(bp_head_r);
  assign depth_w = lp_stage_r ? PTR_W'(LP_DEPTH) : PTR_W'(BP_DEPTH);
  assign cnt_w   = PTR_W'(tap_cnt_r);
  assign rd_w    = (cnt_w > head_w) ? head_w + depth_w - cnt_w : head_w - cnt_w;

  // The new sample overwrites the oldest entry once all taps have been read.
  assign bp_we    = (clearing && (clr_cnt_r < COEF_IDX_W'(BP_DEPTH))) ||
                    ((state_r == S_SUM) && !lp_stage_r);
  assign lp_we    = (clearing && (clr_cnt_r < COEF_IDX_W'(LP_DEPTH))) ||
                    ((state_r == S_SUM) && lp_stage_r);
  assign bp_waddr = clearing ? clr_cnt_r[BP_AW-1:0] : bp_next;
  assign lp_waddr = clearing ? clr_cnt_r[LP_AW-1:0] : lp_next;
  assign bp_wdata = clearing ? '0 : x_r;
  assign lp_wdata = clearing ? '0 : x_r;

  vsbm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BP_DEPTH)
  ) u_bp_hist (
    .clk   (clk),
    .we    (bp_we),
    .waddr (bp_waddr),
    .wdata (bp_wdata),
    .raddr (rd_w[BP_AW-1:0]),
    .rdata (bp_rdata)
  );

  vsbm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (LP_DEPTH)
  ) u_lp_hist (
    .clk   (clk),
    .we    (lp_we),
    .waddr (lp_waddr),
    .wdata (lp_wdata),
    .raddr (rd_w[LP_AW-1:0]),
    .rdata (lp_rdata)
  );

  // --------------------------------------------------------------------------
  // Shared multiplier
  // --------------------------------------------------------------------------
  assign coef    = lp_stage_r ? lp_coef_f(tap_cnt_r) : bp_coef_f(tap_cnt_r);
  assign hist_rd = lp_stage_r ? lp_rdata : bp_rdata;

  always_comb begin
    mul_a   = MUL_W'(x_r);
    mul_b   = MUL_W'(coef);
    prod_en = 1'b0;
    case (state_r)
      S_MIX: begin
        mul_a   = lp_stage_r ? MUL_W'(vsb_r) : MUL_W'(msg_r);
        mul_b   = MUL_W'(car_r);
        prod_en = 1'b1;
      end
      S_MAC: begin
        // Tap zero is the incoming sample; later taps come from memory.
        mul_a   = (tap_cnt_r == '0) ? MUL_W'(x_r) : MUL_W'(hist_rd);
        mul_b   = MUL_W'(coef);
        prod_en = 1'b1;
      end
      S_GAIN: begin
        mul_a   = MUL_W'(lp_r);
        mul_b   = {1'b0, gain_r};
        prod_en = 1'b1;
      end
      default: begin
        prod_en = 1'b0;
      end
    endcase
  end

  assign prod_nxt  = mul_a * mul_b;
  assign prod_ext  = ACC_W'(prod_r);
  assign mix_val   = sat16_f(prod_ext >>> Q15_SHIFT);
  assign fir_val   = sat16_f(acc_r >>> Q15_SHIFT);
  assign scale_val = sat16_f(prod_ext >>> Q13_SHIFT);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_cnt_r == CLR_LAST) state_nxt = S_IDLE;
      S_IDLE:  if (in_beat) state_nxt = S_MIX;
      S_MIX:   state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_MAC;
      S_MAC:   if (tap_cnt_r == tap_last) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_SUM;
      S_SUM:   state_nxt = lp_stage_r ? S_GAIN : S_MIX;
      S_GAIN:  state_nxt = S_SCALE;
      S_SCALE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      lp_stage_r   <= 1'b0;
      tap_cnt_r    <= '0;
      clr_cnt_r    <= '0;
      bp_head_r    <= '0;
      lp_head_r    <= '0;
      mac_vld_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mac_vld_r <= (state_r == S_MAC);
      if (clearing) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (in_beat) begin
        lp_stage_r <= 1'b0;
      end
      if (state_r == S_LOAD) begin
        tap_cnt_r <= '0;
      end else if (state_r == S_MAC) begin
        tap_cnt_r <= tap_cnt_r + 1'b1;
      end
      if (state_r == S_SUM) begin
        lp_stage_r <= 1'b1;
        if (lp_stage_r) begin
          lp_head_r <= lp_next;
        end else begin
          bp_head_r <= bp_next;
        end
      end
      if ((state_r == S_SCALE) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      msg_r <= in_tdata[15:0];
      car_r <= in_tdata[31:16];
    end
    if (prod_en) begin
      prod_r <= prod_nxt;
    end
    if (state_r == S_LOAD) begin
      x_r   <= mix_val;
      acc_r <= '0;
    end else if (mac_vld_r) begin
      acc_r <= acc_r + prod_ext;
    end
    if (state_r == S_SUM) begin
      if (lp_stage_r) begin
        lp_r <= fir_val;
      end else begin
        vsb_r <= fir_val;
      end
    end
    if ((state_r == S_SCALE) && out_free) begin
      out_tdata_r <= {scale_val, vsb_r};
    end
  end

`ifndef NO_ASSERTIONS
  a_tap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (tap_cnt_r <= tap_last))
    else $error("tap counter ran past the last tap");

  a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (bp_head_r <= BP_AW'(BP_DEPTH - 1)) && (lp_head_r <= LP_AW'(LP_DEPTH - 1)))
    else $error("history head pointer outside its memory");

  a_result_from_scale: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_SCALE))
    else $error("result beat raised outside the scaling step");

  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    (bp_we || lp_we) |-> (state_r == S_CLEAR || state_r == S_SUM))
    else $error("history memory written while taps are being read");
`endif

endmodule

`default_nettype wire
